[src/assert_macros.svh]
// Assertion macros shared by the deframer RTL.
// Standalone header; expands to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is low
`define LPRD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled while reset is low
`define LPRD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LPRD_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define LPRD_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

[src/lprd_pkg.sv]
// Types and constants for the length-prefixed record deframer.
// No dependencies; used by lprd_parser and the top level.
package lprd_pkg;

    localparam int unsigned LEN_W     = 32;
    localparam int unsigned CFG_IDX_W = 1;

    // largest key or value length accepted
    localparam logic [LEN_W-1:0] LEN_MAX = 32'd1048576;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BYTES = 1'd1;

    typedef enum logic [2:0] {
        PH_KLEN = 3'd0,
        PH_KEY  = 3'd1,
        PH_FLAG = 3'd2,
        PH_VLEN = 3'd3,
        PH_VAL  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ROLE_KLEN    = 3'd0,
        ROLE_KEY     = 3'd1,
        ROLE_FLAG    = 3'd2,
        ROLE_VLEN    = 3'd3,
        ROLE_VAL     = 3'd4,
        ROLE_IGNORED = 3'd5
    } role_t;

    typedef enum logic [2:0] {
        ST_RUN     = 3'd0,
        ST_DONE    = 3'd1,
        ST_TRUNC   = 3'd2,
        ST_BIG     = 3'd3,
        ST_OVERRUN = 3'd4
    } stop_t;

    // one tagged output word
    typedef struct packed {
        logic [7:0]       byte_out;
        role_t            role;
        logic [LEN_W-1:0] key_length;
        logic [LEN_W-1:0] value_length;
        logic [7:0]       record_flag;
        logic [LEN_W-1:0] record_number;
        logic             last;
        stop_t            stop;
    } lprd_result_t;

endpackage

[src/lprd_parser.sv]
// Record parsing state and the per-byte update of the deframer.
// Depends on lprd_pkg. The result for the byte on data_byte is combinational;
// state advances when step is high.
module lprd_parser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic [7:0]                 data_byte,
    input  logic [lprd_pkg::LEN_W-1:0] entry_limit,
    input  logic [lprd_pkg::LEN_W-1:0] region_bytes,
    output lprd_pkg::lprd_result_t     res
);

    lprd_pkg::phase_t            phase_reg, phase_next;
    logic [1:0]                  fbc_reg, fbc_next;
    logic [lprd_pkg::LEN_W-1:0]  left_reg, left_next;
    logic [lprd_pkg::LEN_W-1:0]  klen_reg, klen_next;
    logic [lprd_pkg::LEN_W-1:0]  vlen_reg, vlen_next;
    logic [7:0]                  flag_reg, flag_next;
    logic [lprd_pkg::LEN_W-1:0]  count_reg, count_next;
    logic [lprd_pkg::LEN_W-1:0]  offset_reg, offset_next;
    lprd_pkg::stop_t             stopped_reg, stopped_next;

    logic                        at_start;
    logic                        hdr_trunc;
    logic [lprd_pkg::LEN_W-1:0]  lane;
    logic [lprd_pkg::LEN_W-1:0]  klen_base;
    logic [lprd_pkg::LEN_W-1:0]  vlen_base;
    logic [lprd_pkg::LEN_W-1:0]  klen_asm;
    logic [lprd_pkg::LEN_W-1:0]  vlen_asm;
    logic [lprd_pkg::LEN_W+1:0]  key_end;
    logic [lprd_pkg::LEN_W+1:0]  val_end;
    logic [lprd_pkg::LEN_W+1:0]  region_x;
    logic [lprd_pkg::LEN_W-1:0]  left_dec;
    logic                        end_rec;
    lprd_pkg::stop_t             st_chk;

    // record-start checks and length assembly
    always_comb begin
        at_start  = (stopped_reg == lprd_pkg::ST_RUN) && (phase_reg == lprd_pkg::PH_KLEN)
                    && (fbc_reg == 2'd0);
        hdr_trunc = ({1'b0, offset_reg} + 33'd4) > {1'b0, region_bytes};
        lane      = {24'd0, data_byte} << {fbc_reg, 3'b000};
        klen_base = at_start ? '0 : klen_reg;
        vlen_base = at_start ? '0 : vlen_reg;
        klen_asm  = klen_base | lane;
        vlen_asm  = vlen_base | lane;
        region_x  = {2'b00, region_bytes};
        // offset of this byte plus one, then key, flag and value length
        key_end   = {2'b00, offset_reg} + 34'd6 + {2'b00, klen_asm};
        val_end   = {2'b00, offset_reg} + 34'd1 + {2'b00, vlen_asm};
        left_dec  = left_reg - 32'd1;
        st_chk    = stopped_reg;
        if (at_start) begin
            if (count_reg >= entry_limit) begin
                st_chk = lprd_pkg::ST_DONE;
            end else if (hdr_trunc) begin
                st_chk = lprd_pkg::ST_TRUNC;
            end
        end
    end

    // per-byte state update
    always_comb begin
        phase_next   = phase_reg;
        fbc_next     = fbc_reg;
        left_next    = left_reg;
        klen_next    = klen_reg;
        vlen_next    = vlen_reg;
        flag_next    = flag_reg;
        count_next   = count_reg;
        offset_next  = offset_reg;
        stopped_next = st_chk;
        end_rec      = 1'b0;
        res.role     = lprd_pkg::ROLE_IGNORED;

        if (at_start && st_chk == lprd_pkg::ST_RUN) begin
            klen_next = '0;
            vlen_next = '0;
            flag_next = '0;
        end

        if (st_chk == lprd_pkg::ST_RUN) begin
            case (phase_reg)
                lprd_pkg::PH_KLEN: begin
                    res.role  = lprd_pkg::ROLE_KLEN;
                    klen_next = klen_asm;
                    if (fbc_reg == 2'd3) begin
                        fbc_next = 2'd0;
                        if (key_end > region_x) begin
                            stopped_next = lprd_pkg::ST_TRUNC;
                        end else if (klen_asm > lprd_pkg::LEN_MAX) begin
                            stopped_next = lprd_pkg::ST_BIG;
                        end else if (klen_asm == '0) begin
                            phase_next = lprd_pkg::PH_FLAG;
                        end else begin
                            left_next  = klen_asm;
                            phase_next = lprd_pkg::PH_KEY;
                        end
                    end else begin
                        fbc_next = fbc_reg + 2'd1;
                    end
                end
                lprd_pkg::PH_KEY: begin
                    res.role  = lprd_pkg::ROLE_KEY;
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        phase_next = lprd_pkg::PH_FLAG;
                    end
                end
                lprd_pkg::PH_FLAG: begin
                    res.role   = lprd_pkg::ROLE_FLAG;
                    flag_next  = data_byte;
                    fbc_next   = 2'd0;
                    phase_next = lprd_pkg::PH_VLEN;
                end
                lprd_pkg::PH_VLEN: begin
                    res.role  = lprd_pkg::ROLE_VLEN;
                    vlen_next = vlen_asm;
                    if (fbc_reg == 2'd3) begin
                        fbc_next = 2'd0;
                        if (vlen_asm > lprd_pkg::LEN_MAX) begin
                            stopped_next = lprd_pkg::ST_BIG;
                        end else if (val_end > region_x) begin
                            stopped_next = lprd_pkg::ST_OVERRUN;
                        end else if (vlen_asm == '0) begin
                            end_rec = 1'b1;
                        end else begin
                            left_next  = vlen_asm;
                            phase_next = lprd_pkg::PH_VAL;
                        end
                    end else begin
                        fbc_next = fbc_reg + 2'd1;
                    end
                end
                default: begin
                    res.role  = lprd_pkg::ROLE_VAL;
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        end_rec = 1'b1;
                    end
                end
            endcase
            if (end_rec) begin
                count_next = count_reg + 32'd1;
                phase_next = lprd_pkg::PH_KLEN;
                fbc_next   = 2'd0;
            end
            // offset saturates at all ones
            if (offset_reg != '1) begin
                offset_next = offset_reg + 32'd1;
            end
        end

        res.byte_out      = data_byte;
        res.key_length    = klen_next;
        res.value_length  = vlen_next;
        res.record_flag   = flag_next;
        res.record_number = count_reg;
        res.last          = end_rec;
        res.stop          = stopped_next;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= lprd_pkg::PH_KLEN;
            fbc_reg     <= 2'd0;
            left_reg    <= '0;
            klen_reg    <= '0;
            vlen_reg    <= '0;
            flag_reg    <= '0;
            count_reg   <= '0;
            offset_reg  <= '0;
            stopped_reg <= lprd_pkg::ST_RUN;
        end else if (step) begin
            phase_reg   <= phase_next;
            fbc_reg     <= fbc_next;
            left_reg    <= left_next;
            klen_reg    <= klen_next;
            vlen_reg    <= vlen_next;
            flag_reg    <= flag_next;
            count_reg   <= count_next;
            offset_reg  <= offset_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

[src/length_prefixed_record_deframer.sv]
// Length-prefixed record deframer: tags each byte of a table's data region with its
// role (key length, key, flag, value length, value, or ignored once stopped) and
// reports the assembled lengths, flag, record number, end of record and stop status.
// Throughput is one byte per cycle while m_ready keeps the output draining; each byte
// passes the input register, then the parser's state update into the result
// register. Once a stop status is reached the block stays stopped until reset.
// Write entry_limit and region_bytes while idle.
// Depends on lprd_pkg, lprd_parser and assert_macros.svh.
`include "assert_macros.svh"

module length_prefixed_record_deframer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lprd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lprd_pkg::LEN_W-1:0]     cfg_data,
    // byte input
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_data_byte,
    // tagged byte output
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_byte_out,
    output logic [2:0]                     m_role,
    output logic [lprd_pkg::LEN_W-1:0]     m_key_length,
    output logic [lprd_pkg::LEN_W-1:0]     m_value_length,
    output logic [7:0]                     m_record_flag,
    output logic [lprd_pkg::LEN_W-1:0]     m_record_number,
    output logic                           m_last_of_record,
    output logic [2:0]                     m_stop_status
);

    logic [lprd_pkg::LEN_W-1:0] entry_limit_reg;
    logic [lprd_pkg::LEN_W-1:0] region_bytes_reg;
    logic                       in_valid_reg;
    logic [7:0]                 in_byte_reg;
    logic                       m_valid_reg;
    lprd_pkg::lprd_result_t     m_res_reg;
    lprd_pkg::lprd_result_t     res;
    logic                       advance;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_limit_reg  <= '0;
            region_bytes_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                lprd_pkg::CFG_ENTRY_LIMIT:  entry_limit_reg  <= cfg_data;
                lprd_pkg::CFG_REGION_BYTES: region_bytes_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // byte moves from input register to result register when the result slot frees
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    lprd_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .data_byte    (in_byte_reg),
        .entry_limit  (entry_limit_reg),
        .region_bytes (region_bytes_reg),
        .res          (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_res_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_byte_out       = m_res_reg.byte_out;
    assign m_role           = m_res_reg.role;
    assign m_key_length     = m_res_reg.key_length;
    assign m_value_length   = m_res_reg.value_length;
    assign m_record_flag    = m_res_reg.record_flag;
    assign m_record_number  = m_res_reg.record_number;
    assign m_last_of_record = m_res_reg.last;
    assign m_stop_status    = m_res_reg.stop;

    // checks
    `LPRD_ASSERT_NXT(a_stop_sticky, aclk, aresetn, advance && res.stop != lprd_pkg::ST_RUN, res.stop == $past(res.stop), "stop status changed after stopping")
    `LPRD_ASSERT_IMP(a_last_role, aclk, aresetn, m_valid_reg && m_res_reg.last, m_res_reg.role == lprd_pkg::ROLE_VLEN || m_res_reg.role == lprd_pkg::ROLE_VAL, "record end outside value fields")
    `LPRD_ASSERT_IMP(a_ignored_running, aclk, aresetn, advance && res.role == lprd_pkg::ROLE_IGNORED, res.stop != lprd_pkg::ST_RUN && !res.last, "ignored word while running")

endmodule

[dv/testbench.sv]
// Self-checking testbench for length_prefixed_record_deframer: feeds record streams
// under random handshake gaps and compares every tagged output word with a local model.
// Depends on lprd_pkg and the deframer RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_BYTES = 830;

    typedef enum int unsigned {
        CFG_OPEN,
        CFG_EXACT,
        CFG_SLACK
    } limit_mode_t;

    typedef enum int unsigned {
        END_ALL_PARSED,
        END_SHORT_HEADER,
        END_SHORT_KEY,
        END_BIG_KEY,
        END_BIG_VALUE,
        END_VALUE_OVERRUN
    } end_kind_t;

    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           cfg_valid   = 1'b0;
    logic                           cfg_ready;
    logic [lprd_pkg::CFG_IDX_W-1:0] cfg_index   = lprd_pkg::CFG_ENTRY_LIMIT;
    logic [lprd_pkg::LEN_W-1:0]     cfg_data    = '0;
    logic                           s_valid     = 1'b0;
    logic                           s_ready;
    logic [7:0]                     s_data_byte = 8'h00;
    logic                           m_valid;
    logic                           m_ready     = 1'b0;
    logic [7:0]                     m_byte_out;
    logic [2:0]                     m_role;
    logic [lprd_pkg::LEN_W-1:0]     m_key_length;
    logic [lprd_pkg::LEN_W-1:0]     m_value_length;
    logic [7:0]                     m_record_flag;
    logic [lprd_pkg::LEN_W-1:0]     m_record_number;
    logic                           m_last_of_record;
    logic [2:0]                     m_stop_status;

    length_prefixed_record_deframer u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_byte_out       (m_byte_out),
        .m_role           (m_role),
        .m_key_length     (m_key_length),
        .m_value_length   (m_value_length),
        .m_record_flag    (m_record_flag),
        .m_record_number  (m_record_number),
        .m_last_of_record (m_last_of_record),
        .m_stop_status    (m_stop_status)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // run guard
    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // shared bookkeeping
    lprd_pkg::lprd_result_t tagged_words_due[$];
    int unsigned            fail_count = 0;
    int unsigned            bytes_fed  = 0;
    logic                   send_burst = 1'b0;
    logic                   recv_burst = 1'b0;

    // deframer model state and register copies
    logic [lprd_pkg::LEN_W-1:0] entry_limit_q  = '0;
    logic [lprd_pkg::LEN_W-1:0] region_bytes_q = '0;
    lprd_pkg::phase_t           phase_q        = lprd_pkg::PH_KLEN;
    logic [1:0]                 len_byte_idx_q = '0;
    logic [lprd_pkg::LEN_W-1:0] field_left_q   = '0;
    logic [lprd_pkg::LEN_W-1:0] key_len_q      = '0;
    logic [lprd_pkg::LEN_W-1:0] val_len_q      = '0;
    logic [7:0]                 flag_q         = '0;
    logic [lprd_pkg::LEN_W-1:0] rec_count_q    = '0;
    logic [lprd_pkg::LEN_W-1:0] offset_q       = '0;
    lprd_pkg::stop_t            stop_q         = lprd_pkg::ST_RUN;

    // advance the model by one byte and return the word it should produce
    function automatic lprd_pkg::lprd_result_t deframe_byte(input logic [7:0] b);
        lprd_pkg::lprd_result_t w;
        logic [35:0]            next_off;
        logic                   rec_done;
        w.byte_out      = b;
        w.role          = lprd_pkg::ROLE_IGNORED;
        w.record_number = rec_count_q;
        w.last          = 1'b0;
        next_off        = {4'd0, offset_q} + 36'd1;
        rec_done        = 1'b0;

        // stop checks at the start of a record
        if (stop_q == lprd_pkg::ST_RUN && phase_q == lprd_pkg::PH_KLEN
                && len_byte_idx_q == 2'd0) begin
            if (rec_count_q >= entry_limit_q) begin
                stop_q = lprd_pkg::ST_DONE;
            end else if ({4'd0, offset_q} + 36'd4 > {4'd0, region_bytes_q}) begin
                stop_q = lprd_pkg::ST_TRUNC;
            end else begin
                key_len_q = '0;
                val_len_q = '0;
                flag_q    = '0;
            end
        end

        if (stop_q == lprd_pkg::ST_RUN) begin
            w.role = lprd_pkg::role_t'(phase_q);
            case (phase_q)
                lprd_pkg::PH_KLEN: begin
                    key_len_q = key_len_q | ({24'd0, b} << (8 * len_byte_idx_q));
                    if (len_byte_idx_q == 2'd3) begin
                        len_byte_idx_q = 2'd0;
                        if (next_off + key_len_q + 36'd5 > {4'd0, region_bytes_q}) begin
                            stop_q = lprd_pkg::ST_TRUNC;
                        end else if (key_len_q > lprd_pkg::LEN_MAX) begin
                            stop_q = lprd_pkg::ST_BIG;
                        end else if (key_len_q == 0) begin
                            phase_q = lprd_pkg::PH_FLAG;
                        end else begin
                            field_left_q = key_len_q;
                            phase_q      = lprd_pkg::PH_KEY;
                        end
                    end else begin
                        len_byte_idx_q++;
                    end
                end
                lprd_pkg::PH_KEY: begin
                    field_left_q--;
                    if (field_left_q == 0) phase_q = lprd_pkg::PH_FLAG;
                end
                lprd_pkg::PH_FLAG: begin
                    flag_q         = b;
                    len_byte_idx_q = 2'd0;
                    phase_q        = lprd_pkg::PH_VLEN;
                end
                lprd_pkg::PH_VLEN: begin
                    val_len_q = val_len_q | ({24'd0, b} << (8 * len_byte_idx_q));
                    if (len_byte_idx_q == 2'd3) begin
                        len_byte_idx_q = 2'd0;
                        if (val_len_q > lprd_pkg::LEN_MAX) begin
                            stop_q = lprd_pkg::ST_BIG;
                        end else if (next_off + val_len_q > {4'd0, region_bytes_q}) begin
                            stop_q = lprd_pkg::ST_OVERRUN;
                        end else if (val_len_q == 0) begin
                            rec_done = 1'b1;
                        end else begin
                            field_left_q = val_len_q;
                            phase_q      = lprd_pkg::PH_VAL;
                        end
                    end else begin
                        len_byte_idx_q++;
                    end
                end
                default: begin
                    field_left_q--;
                    if (field_left_q == 0) rec_done = 1'b1;
                end
            endcase
            if (rec_done) begin
                w.last         = 1'b1;
                rec_count_q++;
                phase_q        = lprd_pkg::PH_KLEN;
                len_byte_idx_q = 2'd0;
            end
            // offset saturates
            if (offset_q != '1) offset_q++;
        end

        w.key_length   = key_len_q;
        w.value_length = val_len_q;
        w.record_flag  = flag_q;
        w.stop         = stop_q;
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // compare each accepted output word with the oldest expectation
    always @(posedge aclk) begin : word_checker
        lprd_pkg::lprd_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (tagged_words_due.size() == 0) begin
                $error("output word 0x%0h with nothing expected", m_byte_out);
                fail_count++;
            end else begin
                want = tagged_words_due.pop_front();
                check_field("byte_out", want.byte_out, m_byte_out);
                check_field("role", want.role, m_role);
                check_field("key_length", want.key_length, m_key_length);
                check_field("value_length", want.value_length, m_value_length);
                check_field("record_flag", want.record_flag, m_record_flag);
                check_field("record_number", want.record_number, m_record_number);
                check_field("last_of_record", want.last, m_last_of_record);
                check_field("stop_status", want.stop, m_stop_status);
            end
        end
    end

    // output side: random stall before taking each word
    initial begin : word_sink
        int unsigned stall;
        wait (aresetn);
        forever begin
            stall = recv_burst ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // one input word; valid is left high so a back-to-back word does not toggle it
    task automatic feed_byte(input logic [7:0] b);
        int unsigned gap;
        gap = send_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        tagged_words_due.push_back(deframe_byte(b));
        bytes_fed++;
    endtask

    // drop valid and wait until every expected word is back
    task automatic drain_words();
        s_valid <= 1'b0;
        while (tagged_words_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // both registers in one burst on the config channel
    task automatic write_regs(input logic [lprd_pkg::LEN_W-1:0] limit,
                              input logic [lprd_pkg::LEN_W-1:0] bytes);
        cfg_valid <= 1'b1;
        cfg_index <= lprd_pkg::CFG_ENTRY_LIMIT;
        cfg_data  <= limit;
        do @(posedge aclk); while (!cfg_ready);
        entry_limit_q = limit;
        cfg_index <= lprd_pkg::CFG_REGION_BYTES;
        cfg_data  <= bytes;
        do @(posedge aclk); while (!cfg_ready);
        region_bytes_q = bytes;
        cfg_valid <= 1'b0;
    endtask

    // one record; oversized key or value bodies are cut short
    task automatic feed_record(input logic [31:0] klen, input logic [7:0] flag,
                               input logic [31:0] vlen);
        int unsigned i;
        for (i = 0; i < 4; i++) feed_byte(klen[8*i +: 8]);
        for (i = 0; i < klen && i < 64; i++) feed_byte($urandom_range(0, 255));
        feed_byte(flag);
        for (i = 0; i < 4; i++) feed_byte(vlen[8*i +: 8]);
        for (i = 0; i < vlen && i < 64; i++) feed_byte($urandom_range(0, 255));
    endtask

    // mostly short fields, now and then a longer one
    function automatic logic [31:0] pick_len();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
    endfunction

    // empty record, then a short one carrying all-zero and all-one bytes
    task automatic test_directed_extremes();
        logic [7:0] rec_bytes[14] = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                      8'h02, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h80,
                                      8'h00, 8'h00};
        int unsigned i;
        write_regs('1, '1);
        send_burst = 1'b1;
        recv_burst = 1'b0;
        feed_record(32'd0, 8'hFF, 32'd0);
        for (i = 0; i < 12; i++) feed_byte(rec_bytes[i]);
        drain_words();
    endtask

    // groups of records under open, exact-fit and loose limits
    task automatic test_random_records();
        logic [31:0] klens[6];
        logic [31:0] vlens[6];
        int unsigned n, total, target, i;
        limit_mode_t mode;
        target = bytes_fed + RANDOM_BYTES;
        while (bytes_fed < target) begin
            n     = $urandom_range(1, 6);
            total = 0;
            for (i = 0; i < n; i++) begin
                klens[i] = pick_len();
                vlens[i] = pick_len();
                total    += 9 + klens[i] + vlens[i];
            end
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
            mode = limit_mode_t'($urandom_range(0, 2));
            case (mode)
                CFG_OPEN: begin
                    write_regs('1, '1);
                end
                CFG_EXACT: begin
                    write_regs(rec_count_q + n, offset_q + total);
                end
                default: begin
                    write_regs(rec_count_q + n + $urandom_range(0, 50),
                               offset_q + total + $urandom_range(0, 500));
                end
            endcase
            for (i = 0; i < n; i++) feed_record(klens[i], $urandom_range(0, 255), vlens[i]);
            drain_words();
        end
    endtask

    // end the stream with one stop cause, then noise that must be ignored
    task automatic test_final_stop();
        end_kind_t   kind;
        logic [31:0] klen, vlen;
        kind = end_kind_t'($urandom_range(0, 5));
        klen = $urandom_range(0, 20);
        vlen = $urandom_range(1, 20);
        send_burst = ($urandom_range(0, 1) == 0);
        recv_burst = ($urandom_range(0, 1) == 0);
        case (kind)
            END_ALL_PARSED: begin
                write_regs(32'd0, '1);
            end
            END_SHORT_HEADER: begin
                write_regs('1, $urandom_range(0, 1) ? 32'd0 : offset_q + $urandom_range(0, 3));
            end
            END_SHORT_KEY: begin
                // header fits, key plus flag plus value length does not
                write_regs('1, offset_q + 8 + klen - $urandom_range(0, 4));
            end
            END_BIG_KEY: begin
                klen = $urandom_range(0, 1)
                       ? lprd_pkg::LEN_MAX + 1
                       : $urandom_range(lprd_pkg::LEN_MAX + 1, 32'hF000_0000);
                write_regs('1, '1);
            end
            END_BIG_VALUE: begin
                vlen = $urandom_range(0, 1)
                       ? lprd_pkg::LEN_MAX + 1
                       : $urandom_range(lprd_pkg::LEN_MAX + 1, 32'hFFFF_FFFF);
                write_regs('1, '1);
            end
            default: begin
                // key fits, value ends past the region
                write_regs('1, offset_q + 9 + klen + $urandom_range(0, vlen - 1));
            end
        endcase
        feed_record(klen, $urandom_range(0, 255), vlen);
        repeat ($urandom_range(30, 60)) feed_byte($urandom_range(0, 255));
        drain_words();
    endtask

    initial begin : main_seq
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_extremes();
        test_random_records();
        test_final_stop();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/lprd_pkg.sv
src/lprd_parser.sv
src/length_prefixed_record_deframer.sv
dv/testbench.sv
